// ===== rtl/core/addressable_led_serial_encoder_assert.svh =====
// Assertion macros used by the LED encoder sequencer (aled_ctrl).
`ifndef ADDRESSABLE_LED_SERIAL_ENCODER_ASSERT_SVH
`define ADDRESSABLE_LED_SERIAL_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define ALED_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("aled: assertion failed");
`define ALED_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aled: assertion failed");
`else
`define ALED_ASSERT(name, clk, rst_n, prop)
`define ALED_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/aled_pkg.sv =====
package aled_pkg;

	localparam int PIXEL_COUNT_DEF = 64;

	localparam int KIND_W  = 2;
	localparam int INDEX_W = 10;
	localparam int WORD_W  = 32;
	localparam int TICK_W  = 16;
	localparam int DUTY_W  = 8;
	localparam int BIT_W   = 5;
	localparam int CFGI_W  = 3;
	localparam int CFGD_W  = 16;

	// input word kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

	// line sequencer phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;
	localparam logic [1:0] PH_GAP  = 2'd3;

	// register indexes
	localparam logic [CFGI_W-1:0] CFG_BIT_PERIOD = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_ONE_HIGH   = 3'd1;
	localparam logic [CFGI_W-1:0] CFG_ZERO_HIGH  = 3'd2;
	localparam logic [CFGI_W-1:0] CFG_LATCH_GAP  = 3'd3;
	localparam logic [CFGI_W-1:0] CFG_FOUR_CHAN  = 3'd4;

	localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 16'd60;
	localparam logic [DUTY_W-1:0] ONE_HIGH_RST   = 8'd38;
	localparam logic [DUTY_W-1:0] ZERO_HIGH_RST  = 8'd19;
	localparam logic [TICK_W-1:0] LATCH_GAP_RST  = 16'd14400;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] pixel_index;
		logic [WORD_W-1:0]  colour_word;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic frame_pending;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] bit_period_ticks;
		logic [DUTY_W-1:0] one_high_ticks;
		logic [DUTY_W-1:0] zero_high_ticks;
		logic [TICK_W-1:0] latch_gap_ticks;
		logic              four_channel_mode;
	} cfg_t;

	// sequencer state after the word held in stage 1, plus its store bypass
	typedef struct packed {
		logic              valid;
		logic [1:0]        phase;
		logic [TICK_W-1:0] tick;
		logic [BIT_W-1:0]  bit_pos;
		logic              pending;
		logic              done;
		logic              byp_hit;
		logic [WORD_W-1:0] byp_word;
	} stat_t;

endpackage

// ===== rtl/core/addressable_led_serial_encoder.sv =====
// One-wire addressable LED strip encoder.
// in channel (in_valid/in_ready/in_item): each word is a pixel write, a start,
//   a stop or one line clock tick. A start begins a frame (all pixels, MSB first,
//   one low tail bit, then the low latch gap) and turns on continuous repeat.
// out channel (out_valid/out_ready/out_item): exactly one word per input word,
//   in order: the line level after that word, the first-frame pending flag and
//   a done strobe on the tick that ends a latch gap.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): timing, 24/32 bit mode
//   regs, always ready; user must write only while block is quiet (unchecked).
// Throughput is one word per cycle unless the output stalls or the reset sweep
//   runs: the sequencer updates in the accept cycle while the pixel store read
//   of the new position is registered, then the line level is formed and
//   registered into the output stage.
// Reset: registers take their defaults and the pixel store is swept to zero,
//   one entry per cycle, so in_ready stays low until every entry is cleared.
//   Config writes are taken during the sweep.
// When out_ready is low the output word holds, one word waits in stage 1, and
//   in_ready drops until the output drains.
module addressable_led_serial_encoder #(
	parameter int PIXEL_COUNT = aled_pkg::PIXEL_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  aled_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output aled_pkg::out_item_t         out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [aled_pkg::CFGI_W-1:0] cfg_index,
	input  logic [aled_pkg::CFGD_W-1:0] cfg_data
);
	import aled_pkg::*;

	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	cfg_t              cfg;
	stat_t             stat;
	logic              take;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// timing and mode registers
	aled_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: update phase, bit and pixel counters on each accepted word,
	// drive the store write port and the read of the next pixel position
	aled_ctrl #(
		.PIXEL_COUNT (PIXEL_COUNT),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg       (cfg),
		.take      (take),
		.stat      (stat),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	// one colour word per pixel
	aled_ram #(
		.WIDTH (WORD_W),
		.DEPTH (PIXEL_COUNT),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// line level from the fetched word and the tick count; hold under stall
	aled_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.stat      (stat),
		.rdata     (mem_rdata),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/aled_ram.sv =====
module aled_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/aled_cfg.sv =====
module aled_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [aled_pkg::CFGI_W-1:0] cfg_index,
	input  logic [aled_pkg::CFGD_W-1:0] cfg_data,
	output aled_pkg::cfg_t              cfg
);
	import aled_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period_ticks  <= BIT_PERIOD_RST;
			cfg_q.one_high_ticks    <= ONE_HIGH_RST;
			cfg_q.zero_high_ticks   <= ZERO_HIGH_RST;
			cfg_q.latch_gap_ticks   <= LATCH_GAP_RST;
			cfg_q.four_channel_mode <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BIT_PERIOD: cfg_q.bit_period_ticks  <= cfg_data;
				CFG_ONE_HIGH:   cfg_q.one_high_ticks    <= cfg_data[DUTY_W-1:0];
				CFG_ZERO_HIGH:  cfg_q.zero_high_ticks   <= cfg_data[DUTY_W-1:0];
				CFG_LATCH_GAP:  cfg_q.latch_gap_ticks   <= cfg_data;
				CFG_FOUR_CHAN:  cfg_q.four_channel_mode <= cfg_data[0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/aled_ctrl.sv =====
`include "addressable_led_serial_encoder_assert.svh"

module aled_ctrl #(
	parameter int PIXEL_COUNT = aled_pkg::PIXEL_COUNT_DEF,
	parameter int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  aled_pkg::in_item_t          in_item,
	input  aled_pkg::cfg_t              cfg,
	input  logic                        take,
	output aled_pkg::stat_t             stat,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [aled_pkg::WORD_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr
);
	import aled_pkg::*;

	localparam logic [AW:0] PC_EXT   = (AW+1)'(PIXEL_COUNT);
	localparam logic [AW:0] PC_LAST  = (AW+1)'(PIXEL_COUNT - 1);
	localparam logic [INDEX_W:0] PC_IDX = (INDEX_W+1)'(PIXEL_COUNT);

	logic [1:0]        phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [BIT_W-1:0]  bit_q, bit_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic              cont_q, cont_d;
	logic              pend_q, pend_d;
	logic              done_d;
	logic              we_item;
	logic              accept;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_idx_q;

	logic              valid_s1;
	logic              done_s1;
	logic              byp_hit_s1;
	logic [WORD_W-1:0] byp_word_s1;

	logic [TICK_W:0]   tick_inc;
	logic [TICK_W-1:0] per_len;
	logic [TICK_W-1:0] gap_len;
	logic              end_bit;
	logic              end_gap;
	logic [BIT_W:0]    bit_inc;
	logic [BIT_W:0]    bpp;
	logic              end_pix;
	logic [AW:0]       pos_inc;
	logic              end_frame;
	logic              idx_ok;

	assign in_ready = !clr_busy_q && (!valid_s1 || take);
	assign accept   = in_valid && in_ready;

	assign tick_inc  = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign per_len   = (cfg.bit_period_ticks == '0) ? TICK_W'(1) : cfg.bit_period_ticks;
	assign gap_len   = (cfg.latch_gap_ticks == '0) ? TICK_W'(1) : cfg.latch_gap_ticks;
	assign end_bit   = tick_inc[TICK_W] || (tick_inc[TICK_W-1:0] >= per_len);
	assign end_gap   = tick_inc[TICK_W] || (tick_inc[TICK_W-1:0] >= gap_len);
	assign bit_inc   = {1'b0, bit_q} + (BIT_W+1)'(1);
	assign bpp       = cfg.four_channel_mode ? (BIT_W+1)'(32) : (BIT_W+1)'(24);
	assign end_pix   = bit_inc >= bpp;
	assign pos_inc   = {1'b0, pos_q} + (AW+1)'(1);
	assign end_frame = pos_inc >= PC_EXT;
	assign idx_ok    = {1'b0, in_item.pixel_index} < PC_IDX;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		pos_d   = pos_q;
		cont_d  = cont_q;
		pend_d  = pend_q;
		done_d  = 1'b0;
		we_item = 1'b0;
		if (accept) begin
			unique case (in_item.kind)
				KIND_WRITE: we_item = idx_ok && !pend_q;
				KIND_START: begin
					if (!cont_q && !pend_q) begin
						pend_d  = 1'b1;
						phase_d = PH_DATA;
						tick_d  = '0;
						bit_d   = '0;
						pos_d   = '0;
					end
					cont_d = 1'b1;
				end
				KIND_STOP: begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					bit_d   = '0;
					pos_d   = '0;
					cont_d  = 1'b0;
					pend_d  = 1'b0;
				end
				KIND_TICK: begin
					unique case (phase_q)
						PH_IDLE: ;
						PH_DATA: begin
							tick_d = tick_inc[TICK_W-1:0];
							if (end_bit) begin
								tick_d = '0;
								bit_d  = bit_inc[BIT_W-1:0];
								if (end_pix) begin
									bit_d = '0;
									pos_d = pos_inc[AW-1:0];
									if (end_frame) begin
										pos_d   = '0;
										phase_d = PH_TAIL;
									end
								end
							end
						end
						PH_TAIL: begin
							tick_d = tick_inc[TICK_W-1:0];
							if (end_bit) begin
								tick_d  = '0;
								phase_d = PH_GAP;
							end
						end
						PH_GAP: begin
							tick_d = tick_inc[TICK_W-1:0];
							if (end_gap) begin
								done_d  = 1'b1;
								pend_d  = 1'b0;
								tick_d  = '0;
								bit_d   = '0;
								pos_d   = '0;
								phase_d = cont_q ? PH_DATA : PH_IDLE;
							end
						end
					endcase
				end
			endcase
		end
	end

	// store write port: zero sweep after reset, then pixel writes
	assign mem_we    = clr_busy_q || we_item;
	assign mem_waddr = clr_busy_q ? clr_idx_q : in_item.pixel_index[AW-1:0];
	assign mem_wdata = clr_busy_q ? '0 : in_item.colour_word;
	assign mem_re    = accept;
	assign mem_raddr = pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_q      <= '0;
			pos_q      <= '0;
			cont_q     <= 1'b0;
			pend_q     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			valid_s1   <= 1'b0;
			done_s1    <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			pos_q   <= pos_d;
			cont_q  <= cont_d;
			pend_q  <= pend_d;
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if ({1'b0, clr_idx_q} == PC_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1   <= 1'b1;
				done_s1    <= done_d;
				byp_hit_s1 <= we_item && (in_item.pixel_index[AW-1:0] == pos_d);
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_word_s1 <= in_item.colour_word;
		end
	end

	assign stat.valid    = valid_s1;
	assign stat.phase    = phase_q;
	assign stat.tick     = tick_q;
	assign stat.bit_pos  = bit_q;
	assign stat.pending  = pend_q;
	assign stat.done     = done_s1;
	assign stat.byp_hit  = byp_hit_s1;
	assign stat.byp_word = byp_word_s1;

	`ALED_ASSERT(a_idle_counters_zero, clk, arst_n,
		(phase_q == PH_IDLE) |-> (tick_q == '0 && bit_q == '0 && pos_q == '0))
	`ALED_ASSERT(a_pending_not_idle, clk, arst_n, pend_q |-> (phase_q != PH_IDLE))
	`ALED_ASSERT(a_tail_gap_positions_zero, clk, arst_n,
		(phase_q == PH_TAIL || phase_q == PH_GAP) |-> (bit_q == '0 && pos_q == '0))
	`ALED_ASSERT_NEXT(a_stop_goes_idle, clk, arst_n, accept && in_item.kind == KIND_STOP,
		phase_q == PH_IDLE && !pend_q && !cont_q)

endmodule

// ===== rtl/core/aled_emit.sv =====
module aled_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aled_pkg::cfg_t              cfg,
	input  aled_pkg::stat_t             stat,
	input  logic [aled_pkg::WORD_W-1:0] rdata,
	output logic                        take,
	output logic                        out_valid,
	input  logic                        out_ready,
	output aled_pkg::out_item_t         out_item
);
	import aled_pkg::*;

	logic              out_valid_q;
	out_item_t         out_item_q;
	logic [WORD_W-1:0] word;
	logic [BIT_W:0]    bpp;
	logic [BIT_W-1:0]  sel;
	logic              cur_bit;
	logic [DUTY_W-1:0] high;
	logic              level;

	assign take = !out_valid_q || out_ready;

	// pick the current bit, most significant used bit first
	assign word    = stat.byp_hit ? stat.byp_word : rdata;
	assign bpp     = cfg.four_channel_mode ? (BIT_W+1)'(32) : (BIT_W+1)'(24);
	assign sel     = (cfg.four_channel_mode ? BIT_W'(31) : BIT_W'(23)) - stat.bit_pos;
	assign cur_bit = ({1'b0, stat.bit_pos} < bpp) ? word[sel] : 1'b0;
	assign high    = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
	assign level   = (stat.phase == PH_DATA) && (stat.tick < {{(TICK_W-DUTY_W){1'b0}}, high});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= stat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && stat.valid) begin
			out_item_q.line_level    <= level;
			out_item_q.frame_pending <= stat.pending;
			out_item_q.frame_done    <= stat.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
